>>> hdl/chs_pkg.sv
// chs_pkg: types and constants shared by the CubeHash stream hasher.
// No dependencies.
`timescale 1ns / 1ps
package chs_pkg;
   localparam int CUBE_WORDS = 32;
   localparam int MAX_HASH_BYTES = 64;

   typedef logic [31:0] word_type;
   typedef word_type [CUBE_WORDS-1:0] cube_type;

   // configuration register indexes
   localparam logic [2:0] REG_INIT_ROUNDS  = 3'd0;
   localparam logic [2:0] REG_ROUNDS       = 3'd1;
   localparam logic [2:0] REG_BLOCK_BYTES  = 3'd2;
   localparam logic [2:0] REG_FINAL_ROUNDS = 3'd3;
   localparam logic [2:0] REG_HASH_BYTES   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROUND, ST_EMIT
   } state_type;

   // what happens after the current round run
   typedef enum logic [1:0] {
      NEXT_ABSORB, NEXT_PAD, NEXT_FINAL, NEXT_DONE
   } next_type;

   // datapath commands
   typedef struct packed {
      logic       load_init;   // rebuild cube from config
      logic       xor_byte;    // xor byte at position
      logic       xor_pad;     // xor 0x80 at position
      logic       xor_final;   // xor 1 into word 31
      logic       do_round;    // one round
      logic       pos_clear;
      logic       pos_inc;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [6:0] pos;
   } status_type;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic cube_type cube_round(input cube_type c);
      cube_type x;
      cube_type y;
      x = c;
      for (int n = 0; n < 16; n++) x[16+n] = x[16+n] + x[n];
      for (int n = 0; n < 16; n++) x[n] = rotl(x[n], 7);
      y = x;
      for (int n = 0; n < 16; n++) y[n] = x[n ^ 8];
      for (int n = 0; n < 16; n++) y[n] = y[n] ^ y[16+n];
      x = y;
      for (int n = 0; n < 16; n++) x[16+n] = y[16+(n ^ 2)];
      for (int n = 0; n < 16; n++) x[16+n] = x[16+n] + x[n];
      for (int n = 0; n < 16; n++) x[n] = rotl(x[n], 11);
      y = x;
      for (int n = 0; n < 16; n++) y[n] = x[n ^ 4];
      for (int n = 0; n < 16; n++) y[n] = y[n] ^ y[16+n];
      x = y;
      for (int n = 0; n < 16; n++) x[16+n] = y[16+(n ^ 1)];
      cube_round = x;
   endfunction
endpackage

>>> hdl/chs_datapath.sv
// chs_datapath: cube register, round unit, block position and digest byte select.
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_datapath (
   input  logic               clock,
   input  logic               reset,
   input  chs_pkg::cmd_type   cmd,
   input  logic [6:0]         eff_hash,
   input  logic [7:0]         eff_block,
   input  logic [7:0]         rounds_cfg,
   input  logic [5:0]         out_idx,
   output chs_pkg::status_type status,
   output logic [7:0]         out_byte
);
   import chs_pkg::*;

   cube_type   cube_ff, cube_in;
   logic [6:0] pos_ff, pos_in;
   logic [7:0] xb;

   always_comb begin
      cube_in = cube_ff;
      xb = cmd.xor_pad ? 8'h80 : cmd.data;
      if (cmd.load_init) begin
         cube_in = '0;
         cube_in[0] = {25'd0, eff_hash};
         cube_in[1] = {24'd0, eff_block};
         cube_in[2] = {24'd0, rounds_cfg};
      end else if (cmd.do_round) begin
         cube_in = cube_round(cube_ff);
      end else begin
         if (cmd.xor_byte || cmd.xor_pad)
            cube_in[pos_ff[6:2]] = cube_ff[pos_ff[6:2]] ^
                                   ({24'd0, xb} << {pos_ff[1:0], 3'd0});
         if (cmd.xor_final) cube_in[31] = cube_ff[31] ^ 32'd1;
      end
      pos_in = pos_ff;
      if (cmd.pos_clear) pos_in = '0;
      else if (cmd.pos_inc) pos_in = pos_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      cube_ff <= cube_in;
      if (reset) pos_ff <= '0;
      else pos_ff <= pos_in;
   end

   assign status.pos = pos_ff;
   assign out_byte = 8'(cube_ff[out_idx[5:2]] >> {out_idx[1:0], 3'd0});
endmodule

>>> hdl/chs_control.sv
// chs_control: sequencer for message start, absorb, padding, rounds and digest output.
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_msg_byte,
   input  logic                req_has_byte,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_last_byte,
   input  logic [7:0]          init_rounds,
   input  logic [7:0]          rounds_cfg,
   input  logic [7:0]          final_rounds,
   input  logic [7:0]          eff_block,
   input  logic [6:0]          eff_hash,
   input  chs_pkg::status_type status,
   output chs_pkg::cmd_type    cmd,
   output logic [5:0]          out_idx
);
   import chs_pkg::*;

   state_type  state_ff, state_in;
   next_type   next_ff, next_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       open_ff, open_in;
   logic       last_ff, last_in;
   logic       has_ff, has_in;
   logic [7:0] byte_ff, byte_in;
   logic [5:0] idx_ff, idx_in;
   logic       acc, close_blk;
   logic [6:0] pos_next;

   assign acc = req_valid && req_ready;
   assign pos_next = status.pos + 7'd1;
   assign close_blk = (pos_next == 7'd0) || ({1'b0, pos_next} >= eff_block);
   assign out_idx = idx_ff;

   // next state
   always_comb begin
      state_in = state_ff; next_in = next_ff; cnt_in = cnt_ff;
      open_in = open_ff; last_in = last_ff; has_in = has_ff;
      byte_in = byte_ff; idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && (req_has_byte || req_is_last)) begin
               last_in = req_is_last; has_in = req_has_byte; byte_in = req_msg_byte;
               if (!open_ff) begin
                  open_in = 1'b1; state_in = ST_ROUND; cnt_in = init_rounds;
                  next_in = NEXT_ABSORB;
               end else begin
                  // absorb now
                  if (req_has_byte && close_blk) begin
                     state_in = ST_ROUND; cnt_in = rounds_cfg;
                     next_in = req_is_last ? NEXT_PAD : NEXT_DONE;
                  end else if (req_has_byte && req_is_last) begin
                     // pad goes in at the next position, in the following cycle
                     state_in = ST_ROUND; cnt_in = 8'd0; next_in = NEXT_PAD;
                  end else if (req_is_last) begin
                     state_in = ST_ROUND; cnt_in = rounds_cfg; next_in = NEXT_FINAL;
                  end
               end
            end
         end
         ST_ROUND: begin
            if (cnt_ff != 8'd0) cnt_in = cnt_ff - 8'd1;
            else begin
               unique case (next_ff)
                  NEXT_ABSORB: begin
                     if (has_ff && close_blk) begin
                        cnt_in = rounds_cfg; next_in = last_ff ? NEXT_PAD : NEXT_DONE;
                     end else if (has_ff && last_ff) begin
                        next_in = NEXT_PAD;
                     end else if (last_ff) begin
                        cnt_in = rounds_cfg; next_in = NEXT_FINAL;
                     end else state_in = ST_IDLE;
                  end
                  NEXT_PAD: begin cnt_in = rounds_cfg; next_in = NEXT_FINAL; end
                  NEXT_FINAL: begin cnt_in = final_rounds; next_in = NEXT_DONE; end
                  NEXT_DONE: begin
                     if (last_ff) begin state_in = ST_EMIT; idx_in = '0; end
                     else state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if ({1'b0, idx_ff} + 7'd1 == eff_hash) begin
                  state_in = ST_IDLE; open_in = 1'b0;
               end else idx_in = idx_ff + 6'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.data = byte_ff;
      req_ready = 1'b0; rsp_valid = 1'b0; rsp_last_byte = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.data = req_msg_byte;
            if (req_valid && (req_has_byte || req_is_last)) begin
               if (!open_ff) begin
                  cmd.load_init = 1'b1; cmd.pos_clear = 1'b1;
               end else if (req_has_byte) begin
                  cmd.xor_byte = 1'b1;
                  if (close_blk) cmd.pos_clear = 1'b1; else cmd.pos_inc = 1'b1;
               end else cmd.xor_pad = 1'b1;
            end
         end
         ST_ROUND: begin
            if (cnt_ff != 8'd0) cmd.do_round = 1'b1;
            else begin
               unique case (next_ff)
                  NEXT_ABSORB: begin
                     if (has_ff) begin
                        cmd.xor_byte = 1'b1;
                        if (close_blk) cmd.pos_clear = 1'b1; else cmd.pos_inc = 1'b1;
                     end else if (last_ff) cmd.xor_pad = 1'b1;
                  end
                  NEXT_PAD: cmd.xor_pad = 1'b1;
                  NEXT_FINAL: begin cmd.xor_final = 1'b1; cmd.pos_clear = 1'b1; end
                  NEXT_DONE: ;
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last_byte = ({1'b0, idx_ff} + 7'd1 == eff_hash);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; open_ff <= 1'b0; cnt_ff <= '0; next_ff <= NEXT_DONE;
         last_ff <= 1'b0; has_ff <= 1'b0; idx_ff <= '0;
      end else begin
         state_ff <= state_in; open_ff <= open_in; cnt_ff <= cnt_in; next_ff <= next_in;
         last_ff <= last_in; has_ff <= has_in; idx_ff <= idx_in;
      end
      byte_ff <= byte_in;
   end
endmodule

>>> hdl/cubehash_stream_hasher.sv
// CubeHash stream hasher, top level: config registers, controller, datapath.
// Rounds run one per cycle: a block-closing byte runs the configured rounds, and a message
// start first runs init_rounds. An end item pads, runs rounds, flips the final bit and runs
// final_rounds before its digest comes out (a byte that closes a block adds rounds first).
// Digest: one byte per cycle while rsp_ready is high; no input is taken until it is out.
// Reset (synchronous, active high) restores config defaults and closes any message.
`timescale 1ns / 1ps
module cubehash_stream_hasher #(
   parameter int MAX_BLOCK_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_msg_byte,
   input  logic       req_has_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_hash_byte,
   output logic       rsp_last_byte,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);
   import chs_pkg::*;

   // configuration registers
   logic [7:0] init_rounds_ff, rounds_ff, block_bytes_ff, final_rounds_ff;
   logic [6:0] hash_bytes_ff;
   logic [7:0] eff_block;
   logic [6:0] eff_hash;
   cmd_type    cmd;
   status_type status;
   logic [5:0] out_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_rounds_ff <= 8'd16; rounds_ff <= 8'd16; block_bytes_ff <= 8'd32;
         final_rounds_ff <= 8'd32; hash_bytes_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_INIT_ROUNDS:  init_rounds_ff <= csr_data;
            REG_ROUNDS:       rounds_ff <= csr_data;
            REG_BLOCK_BYTES:  block_bytes_ff <= csr_data;
            REG_FINAL_ROUNDS: final_rounds_ff <= csr_data;
            REG_HASH_BYTES:   hash_bytes_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // clamp block size to 1..MAX_BLOCK_BYTES, digest to 1..64
   always_comb begin
      if (block_bytes_ff == 8'd0) eff_block = 8'd1;
      else if (32'(block_bytes_ff) > MAX_BLOCK_BYTES) eff_block = 8'(MAX_BLOCK_BYTES);
      else eff_block = block_bytes_ff;
      if (hash_bytes_ff == 7'd0) eff_hash = 7'd1;
      else if (hash_bytes_ff > 7'(MAX_HASH_BYTES)) eff_hash = 7'(MAX_HASH_BYTES);
      else eff_hash = hash_bytes_ff;
   end

   chs_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_msg_byte, .req_has_byte,
      .req_is_last, .rsp_valid, .rsp_ready, .rsp_last_byte,
      .init_rounds(init_rounds_ff), .rounds_cfg(rounds_ff),
      .final_rounds(final_rounds_ff), .eff_block, .eff_hash, .status, .cmd, .out_idx
   );

   chs_datapath u_datapath (
      .clock, .reset, .cmd, .eff_hash, .eff_block, .rounds_cfg(rounds_ff),
      .out_idx, .status, .out_byte(rsp_hash_byte)
   );
endmodule

>>> dv/tb.sv
// tb: self-checking testbench for cubehash_stream_hasher.
// Depends on chs_pkg (register indexes) and the hasher top level.
`timescale 1ns / 1ps
module tb;
   import chs_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_msg_byte = 8'd0;
   logic       req_has_byte = 1'b0;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_hash_byte;
   logic       rsp_last_byte;
   logic       csr_write = 1'b0;
   logic [2:0] csr_index = REG_INIT_ROUNDS;
   logic [7:0] csr_data = 8'd0;

   cubehash_stream_hasher uut (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       has_byte;
      logic       is_last;
   } msg_item_t;

   typedef struct packed {
      logic [7:0] hash_byte;
      logic       last_byte;
   } digest_byte_t;

   msg_item_t    pending_items[$];
   digest_byte_t digest_queue[$];

   // local copy of hasher state and config
   logic [31:0] cube[32];
   logic [6:0]  blk_pos;
   logic        msg_open;
   logic [7:0]  cfg_init, cfg_rounds, cfg_block, cfg_final;
   logic [6:0]  cfg_hash;

   int send_idle_pct = 0;   // sender gap chance, percent
   int recv_idle_pct = 0;
   int hold_off = 400;      // long receiver stall, in cycles
   int errors = 0;
   int digests_seen = 0;
   int items_sent = 0;
   int watchdog = 0;

   // acceptance seen at the last rising edge
   logic req_ready_q = 1'b0;

   // long receiver stall
   event stall_start;
   logic stall_on = 1'b0;

   function automatic logic [31:0] rotl32(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic mix_round();
      logic [31:0] t;
      for (int n = 0; n < 16; n++) cube[16+n] += cube[n];
      for (int n = 0; n < 16; n++) cube[n] = rotl32(cube[n], 7);
      for (int n = 0; n < 8; n++) begin
         t = cube[n]; cube[n] = cube[n+8]; cube[n+8] = t;
      end
      for (int n = 0; n < 16; n++) cube[n] ^= cube[16+n];
      for (int n = 0; n < 16; n++) begin
         if (!n[1]) begin
            t = cube[16+n]; cube[16+n] = cube[18+n]; cube[18+n] = t;
         end
      end
      for (int n = 0; n < 16; n++) cube[16+n] += cube[n];
      for (int n = 0; n < 16; n++) cube[n] = rotl32(cube[n], 11);
      for (int n = 0; n < 16; n++) begin
         if (!n[2]) begin
            t = cube[n]; cube[n] = cube[n+4]; cube[n+4] = t;
         end
      end
      for (int n = 0; n < 16; n++) cube[n] ^= cube[16+n];
      for (int n = 0; n < 16; n += 2) begin
         t = cube[16+n]; cube[16+n] = cube[17+n]; cube[17+n] = t;
      end
   endtask

   task automatic mix_rounds(int count);
      for (int i = 0; i < count; i++) mix_round();
   endtask

   function automatic int eff_block();
      if (cfg_block == 0) return 1;
      if (cfg_block > 128) return 128;
      return cfg_block;
   endfunction

   function automatic int eff_hash();
      if (cfg_hash == 0) return 1;
      if (cfg_hash > 64) return 64;
      return cfg_hash;
   endfunction

   task automatic xor_at(logic [6:0] pos, logic [7:0] v);
      cube[pos[6:2]] ^= 32'(v) << (pos[1:0] * 8);
   endtask

   // advance the hasher model by one accepted transaction
   task automatic hash_predict(msg_item_t it);
      digest_byte_t d;
      int h;
      if (!it.has_byte && !it.is_last) return;
      if (!msg_open) begin
         foreach (cube[n]) cube[n] = '0;
         cube[0] = eff_hash();
         cube[1] = eff_block();
         cube[2] = cfg_rounds;
         mix_rounds(cfg_init);
         blk_pos = 0;
         msg_open = 1'b1;
      end
      if (it.has_byte) begin
         xor_at(blk_pos, it.msg_byte);
         blk_pos = blk_pos + 7'd1;
         if (blk_pos == 0 || blk_pos >= eff_block()) begin
            mix_rounds(cfg_rounds);
            blk_pos = 0;
         end
      end
      if (!it.is_last) return;
      xor_at(blk_pos, 8'h80);
      mix_rounds(cfg_rounds);
      blk_pos = 0;
      cube[31] ^= 32'd1;
      mix_rounds(cfg_final);
      h = eff_hash();
      for (int n = 0; n < h; n++) begin
         d.hash_byte = 8'(cube[n >> 2] >> ((n % 4) * 8));
         d.last_byte = (n + 1 == h);
         digest_queue.push_back(d);
      end
      msg_open = 1'b0;
   endtask

   // driver: offer the next pending transaction, hold until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_q) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               {req_msg_byte, req_has_byte, req_is_last} <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && pending_items.size() > 0
                      && $urandom_range(99) >= send_idle_pct) begin
            {req_msg_byte, req_has_byte, req_is_last} <= pending_items.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // receiver: random ready, forced low during a long stall
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_on) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // long stall length counted here
   always begin
      @(stall_start);
      stall_on = 1'b1;
      repeat (hold_off) @(negedge clock);
      stall_on = 1'b0;
   end

   // monitor: predict on input acceptance, check on output acceptance
   always @(posedge clock) begin
      digest_byte_t exp;
      if (reset) begin
         req_ready_q <= 1'b0;
      end else begin
         req_ready_q <= req_valid && req_ready;
         watchdog <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                     0 : watchdog + 1;
         if (req_valid && req_ready) begin
            items_sent <= items_sent + 1;
            hash_predict({req_msg_byte, req_has_byte, req_is_last});
         end
         if (rsp_valid && rsp_ready) begin
            digests_seen <= digests_seen + 1;
            if (digest_queue.size() == 0) begin
               $error("digest byte %h with nothing expected", rsp_hash_byte);
               errors++;
            end else begin
               exp = digest_queue.pop_front();
               if (rsp_hash_byte !== exp.hash_byte) begin
                  $error("hash_byte expected %h actual %h", exp.hash_byte, rsp_hash_byte);
                  errors++;
               end
               if (rsp_last_byte !== exp.last_byte) begin
                  $error("last_byte expected %b actual %b", exp.last_byte, rsp_last_byte);
                  errors++;
               end
            end
         end
         if (watchdog > 40000) begin
            $display("watchdog: no transaction for %0d cycles", watchdog);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // register write, only while idle; mirrors into the model
   task automatic csr_put(logic [2:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_INIT_ROUNDS:  cfg_init   = val;
         REG_ROUNDS:       cfg_rounds = val;
         REG_BLOCK_BYTES:  cfg_block  = val;
         REG_FINAL_ROUNDS: cfg_final  = val;
         REG_HASH_BYTES:   cfg_hash   = val[6:0];
         default: ;
      endcase
   endtask

   task automatic csr_all(int ir, int r, int bb, int fr, int hb);
      csr_put(REG_INIT_ROUNDS, 8'(ir));
      csr_put(REG_ROUNDS, 8'(r));
      csr_put(REG_BLOCK_BYTES, 8'(bb));
      csr_put(REG_FINAL_ROUNDS, 8'(fr));
      csr_put(REG_HASH_BYTES, 8'(hb));
   endtask

   // wait until every queued transaction went in and every digest came out
   task automatic drain();
      wait (pending_items.size() == 0 && !req_valid);
      wait (digest_queue.size() == 0);
      // the block may still be running rounds on a message without output
      repeat (300) @(posedge clock);
   endtask

   task automatic push_msg(int len, bit with_end_byte);
      msg_item_t it;
      for (int i = 0; i < len; i++) begin
         it.msg_byte = $urandom_range(255);
         it.has_byte = 1'b1;
         it.is_last  = with_end_byte && (i == len - 1);
         pending_items.push_back(it);
         // stray idle items now and then
         if ($urandom_range(15) == 0) begin
            it = '{8'($urandom_range(255)), 1'b0, 1'b0};
            pending_items.push_back(it);
         end
      end
      if (!with_end_byte || len == 0) begin
         it = '{8'($urandom_range(255)), 1'b0, 1'b1};
         pending_items.push_back(it);
      end
   endtask

   task automatic random_phase(int nbytes);
      int used;
      used = 0;
      while (used < nbytes) begin
         int len;
         len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12);
         push_msg(len, $urandom_range(1));
         used += len + 1;
      end
   endtask

   initial begin
      cfg_init = 16; cfg_rounds = 16; cfg_block = 32; cfg_final = 32; cfg_hash = 64;
      blk_pos = 0; msg_open = 1'b0;
      foreach (cube[n]) cube[n] = '0;
      send_idle_pct = 37; recv_idle_pct = 51;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: defaults, empty message, byte extremes, block boundary
      pending_items.push_back('{8'h00, 1'b0, 1'b1});
      pending_items.push_back('{8'hff, 1'b1, 1'b1});
      pending_items.push_back('{8'h00, 1'b1, 1'b1});
      drain();
      csr_all(1, 1, 4, 1, 1);
      for (int i = 0; i < 4; i++) pending_items.push_back('{8'hff, 1'b1, 1'b0});
      pending_items.push_back('{8'h55, 1'b0, 1'b1});
      pending_items.push_back('{8'haa, 1'b0, 1'b0});
      pending_items.push_back('{8'h00, 1'b1, 1'b0});
      pending_items.push_back('{8'hff, 1'b1, 1'b1});
      drain();
      // out-of-range sizes and zero rounds
      csr_all(0, 0, 0, 0, 0);
      push_msg(3, 1);
      drain();
      csr_all(2, 1, 200, 2, 127);
      push_msg(5, 1);
      drain();
      csr_all(255, 255, 128, 255, 64);
      push_msg(2, 1);
      drain();

      // random phases at varied settings and idle mixes
      csr_all(4, 2, 3, 5, 9);
      random_phase(150);
      drain();
      send_idle_pct = 51; recv_idle_pct = 37;
      csr_all(1, 1, 1, 1, 64);
      random_phase(150);
      // receiver backs off long while the sender keeps offering
      wait (digest_queue.size() > 0);
      -> stall_start;
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      csr_all(8, 3, 7, 4, 5);
      random_phase(150);
      drain();

      $display("ran %0d transactions, checked %0d digest bytes", items_sent, digests_seen);
      $display("covered register extremes, empty messages, idle items and stalls");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
